// File: sv/lbpc_pkg.sv
// ----------------------------------------------------------------------------
// lbpc_pkg
// Shared types and constants for the LED blink/pulse controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lbpc_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ON     = 3'd1;
    localparam logic [2:0] CMD_OFF    = 3'd2;
    localparam logic [2:0] CMD_TOGGLE = 3'd3;
    localparam logic [2:0] CMD_BLINK  = 3'd4;
    localparam logic [2:0] CMD_PULSE  = 3'd5;

    // Configuration register indexes
    localparam logic REG_PULSE_PERIOD  = 1'b0;
    localparam logic REG_BLINK_DIVIDER = 1'b1;

    // Register reset values
    localparam logic [7:0] PULSE_PERIOD_RST  = 8'd10;
    localparam logic [7:0] BLINK_DIVIDER_RST = 8'd15;

    // Mode target marking pulse mode; zero is steady mode
    localparam logic [7:0] PULSE_MODE  = 8'hff;
    localparam logic [7:0] MODE_STEADY = 8'h00;
    localparam logic [7:0] RAMP_TOP    = 8'hff;

    // Step strobes for the current command
    typedef struct packed {
        logic step;
        logic blink;
    } step_t;

    // Pin drive of one LED
    typedef struct packed {
        logic       level;
        logic       pwm_on;
        logic [7:0] duty;
    } led_drive_t;

endpackage

`default_nettype wire

// File: sv/led_blink_pulse_controller.sv
// ----------------------------------------------------------------------------
// led_blink_pulse_controller
// Two-LED pattern controller: steady, toggle, blink bursts and pulse ramp.
// ----------------------------------------------------------------------------
// Usage notes
//   Input channel (in_valid/in_ready) carries one command per transfer:
//   cmd, led_select and blink_count. A tick command advances the millisecond
//   counter; every pulse_period ticks a pattern step runs on both LEDs.
//   Output channel (out_valid/out_ready) carries one result per command with
//   both LEDs' pin level, PWM enable and duty as they stand after it.
//   The result is registered at the edge that takes the command. Throughput
//   is one command per cycle while out_ready stays high, set by the single
//   output register; the next command is taken while a result is being
//   collected in the same cycle.
//   If the receiver stalls, the result waits in the output register and
//   in_ready drops until it is taken; no state changes meanwhile.
//   Reset clears all LED state to steady-off, the counters to zero and the
//   registers to pulse_period 10 and blink_divider 15.
//   Configuration (cfg_wen/cfg_addr/cfg_wdata) writes take effect at once
//   and should be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_pulse_controller
    import lbpc_pkg::*;
#(
    parameter int MAX_FLASHES = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write port
    input  wire logic       cfg_wen,
    input  wire logic       cfg_addr,
    input  wire logic [7:0] cfg_wdata,
    // command channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] cmd,
    input  wire logic       led_select,
    input  wire logic [7:0] blink_count,
    // result channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            ready_level,
    output logic            ready_pwm_on,
    output logic [7:0]      ready_duty,
    output logic            error_level,
    output logic            error_pwm_on,
    output logic [7:0]      error_duty
);

    logic       fire;
    logic       out_valid_reg;
    step_t      strobes;
    led_drive_t ready_drive, error_drive;
    led_drive_t ready_out_reg, error_out_reg;

    // A command is taken whenever the result register is empty or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    lbpc_timebase u_timebase
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .tick_fire (fire && cmd == CMD_TICK),
        .strobes   (strobes)
    );

    // LED 0: ready
    lbpc_led #(.MAX_FLASHES(MAX_FLASHES)) u_led_ready
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .selected    (!led_select),
        .cmd         (cmd),
        .blink_count (blink_count),
        .strobes     (strobes),
        .drive_next  (ready_drive)
    );

    // LED 1: error
    lbpc_led #(.MAX_FLASHES(MAX_FLASHES)) u_led_error
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .selected    (led_select),
        .cmd         (cmd),
        .blink_count (blink_count),
        .strobes     (strobes),
        .drive_next  (error_drive)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ready_out_reg <= ready_drive;
            error_out_reg <= error_drive;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ready_level  = ready_out_reg.level;
    assign ready_pwm_on = ready_out_reg.pwm_on;
    assign ready_duty   = ready_out_reg.duty;
    assign error_level  = error_out_reg.level;
    assign error_pwm_on = error_out_reg.pwm_on;
    assign error_duty   = error_out_reg.duty;

endmodule

`default_nettype wire

// File: sv/lbpc_timebase.sv
// ----------------------------------------------------------------------------
// lbpc_timebase
// Tick counter, step divider and their configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpc_timebase
    import lbpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wen,
    input  wire logic       cfg_addr,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       tick_fire,
    output step_t           strobes
);

    logic [7:0] pulse_period_reg;
    logic [7:0] blink_divider_reg;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [7:0] step_div_reg, step_div_next;
    logic [7:0] tick_inc, div_inc;

    always_comb
    begin
        tick_inc        = tick_count_reg + 8'd1;
        div_inc         = step_div_reg + 8'd1;
        tick_count_next = tick_count_reg;
        step_div_next   = step_div_reg;
        strobes         = '0;
        if (tick_fire)
        begin
            tick_count_next = tick_inc;
            // "reached or passed" so a lowered period never wraps round
            if (tick_inc >= pulse_period_reg)
            begin
                tick_count_next = '0;
                strobes.step    = 1'b1;
                step_div_next   = div_inc;
                if (div_inc >= blink_divider_reg)
                begin
                    step_div_next = '0;
                    strobes.blink = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_period_reg  <= PULSE_PERIOD_RST;
            blink_divider_reg <= BLINK_DIVIDER_RST;
            tick_count_reg    <= '0;
            step_div_reg      <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            step_div_reg   <= step_div_next;
            if (cfg_wen)
            begin
                case (cfg_addr)
                    REG_PULSE_PERIOD:  pulse_period_reg  <= cfg_wdata;
                    REG_BLINK_DIVIDER: blink_divider_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/lbpc_led.sv
// ----------------------------------------------------------------------------
// lbpc_led
// State and pattern logic of one LED: steady, blink and pulse modes.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpc_led
    import lbpc_pkg::*;
#(
    parameter int MAX_FLASHES = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic       selected,
    input  wire logic [2:0] cmd,
    input  wire logic [7:0] blink_count,
    input  wire step_t      strobes,
    output led_drive_t      drive_next
);

    localparam logic [7:0] MAX_T = 8'(MAX_FLASHES);

    logic [7:0] mode_reg, mode_next;
    logic [4:0] flash_reg, flash_next;
    logic [7:0] ramp_reg, ramp_next;
    logic       down_reg, down_next;
    logic       level_reg, level_next;
    logic       pwm_reg, pwm_next;
    logic [7:0] duty_reg, duty_next;
    logic [4:0] twice;
    logic       ramp_dir;
    logic [7:0] ramp_step;
    logic [7:0] blink_t;

    always_comb
    begin
        mode_next  = mode_reg;
        flash_next = flash_reg;
        ramp_next  = ramp_reg;
        down_next  = down_reg;
        level_next = level_reg;
        pwm_next   = pwm_reg;
        duty_next  = duty_reg;
        twice      = {mode_reg[3:0], 1'b0};
        ramp_dir   = down_reg;
        ramp_step  = ramp_reg;
        blink_t    = (blink_count > mode_reg) ? blink_count : mode_reg;
        if (blink_t < 8'd1)
            blink_t = 8'd1;
        if (blink_t > MAX_T)
            blink_t = MAX_T;

        if (fire)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    if (strobes.step && mode_reg == PULSE_MODE)
                    begin
                        if (ramp_reg == RAMP_TOP)
                            ramp_dir = 1'b1;
                        else if (ramp_reg == 8'd0)
                            ramp_dir = 1'b0;
                        ramp_step = ramp_dir ? ramp_reg - 8'd1 : ramp_reg + 8'd1;
                        down_next = ramp_dir;
                        ramp_next = ramp_step;
                        if (ramp_step == 8'd0)
                        begin
                            pwm_next   = 1'b0;
                            level_next = 1'b0;
                        end
                        else
                        begin
                            duty_next = ramp_step;
                            pwm_next  = 1'b1;
                        end
                    end
                    else if (strobes.step && strobes.blink && mode_reg != MODE_STEADY)
                    begin
                        if (flash_reg == twice)
                        begin
                            // end of pause: start a new burst
                            flash_next = '0;
                            level_next = 1'b1;
                        end
                        else if ({3'b000, flash_reg} < mode_reg)
                        begin
                            level_next = ~level_reg;
                            if (level_reg)
                                flash_next = flash_reg + 5'd1;
                        end
                        else
                        begin
                            flash_next = flash_reg + 5'd1;
                        end
                    end
                end
                CMD_ON:
                begin
                    if (selected)
                    begin
                        pwm_next   = 1'b0;
                        mode_next  = MODE_STEADY;
                        level_next = 1'b1;
                    end
                end
                CMD_OFF:
                begin
                    if (selected)
                    begin
                        pwm_next   = 1'b0;
                        mode_next  = MODE_STEADY;
                        level_next = 1'b0;
                    end
                end
                CMD_TOGGLE:
                begin
                    if (selected)
                    begin
                        pwm_next = 1'b0;
                        if (mode_reg == MODE_STEADY)
                            level_next = ~level_reg;
                        else
                        begin
                            mode_next  = MODE_STEADY;
                            level_next = 1'b0;
                        end
                    end
                end
                CMD_BLINK:
                begin
                    if (selected)
                    begin
                        pwm_next   = 1'b0;
                        mode_next  = blink_t;
                        flash_next = {blink_t[3:0], 1'b0};
                    end
                end
                CMD_PULSE:
                begin
                    if (selected)
                    begin
                        ramp_next = '0;
                        mode_next = PULSE_MODE;
                        down_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        drive_next.level  = level_next;
        drive_next.pwm_on = pwm_next;
        drive_next.duty   = duty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_STEADY;
            flash_reg <= '0;
            ramp_reg  <= '0;
            down_reg  <= 1'b0;
            level_reg <= 1'b0;
            pwm_reg   <= 1'b0;
            duty_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            flash_reg <= flash_next;
            ramp_reg  <= ramp_next;
            down_reg  <= down_next;
            level_reg <= level_next;
            pwm_reg   <= pwm_next;
            duty_reg  <= duty_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/lbpc_checker.sv
// ----------------------------------------------------------------------------
// lbpc_checker
// Port-level checks on the controller's handshakes and results.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpc_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       ready_pwm_on,
    input wire logic [7:0] ready_duty,
    input wire logic       error_pwm_on,
    input wire logic [7:0] error_duty
);

    // Input only stalls while a result is held
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no result pending");

    // Every accepted command gives a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted command produced no result");

    // No result appears without a command
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without a command transfer");

    // PWM is only enabled with a non-zero duty
    a_pwm_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!ready_pwm_on || ready_duty != 8'd0)
                   && (!error_pwm_on || error_duty != 8'd0))
        else $error("PWM enabled with zero duty");

endmodule

bind led_blink_pulse_controller lbpc_checker u_lbpc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ready_pwm_on (ready_pwm_on),
    .ready_duty   (ready_duty),
    .error_pwm_on (error_pwm_on),
    .error_duty   (error_duty)
);

`default_nettype wire
